### design/tdrs_pkg.sv
`timescale 1ns / 1ps

package tdrs_pkg;

  localparam int REGION_W     = 16;
  localparam int PANEL_IDX_W  = 3;
  localparam int LOCAL_W      = 7;
  localparam int CANVAS_COL_W = 10;
  localparam int CANVAS_ROW_W = 7;
  localparam int IN_DATA_W    = 64;
  localparam int OUT_DATA_W   = 72;

  typedef struct packed {
    logic [REGION_W-1:0] bottom;
    logic [REGION_W-1:0] right;
    logic [REGION_W-1:0] top;
    logic [REGION_W-1:0] left;
  } region_t;

  typedef struct packed {
    logic    valid;
    logic    any_hit;
    region_t region;
  } link_t;

  typedef struct packed {
    logic                    hit;
    logic [PANEL_IDX_W-1:0]  panel_index;
    logic [LOCAL_W-1:0]      local_left;
    logic [LOCAL_W-1:0]      local_top;
    logic [LOCAL_W-1:0]      local_right;
    logic [LOCAL_W-1:0]      local_bottom;
    logic [CANVAS_COL_W-1:0] canvas_left;
    logic [CANVAS_ROW_W-1:0] canvas_top;
    logic [CANVAS_COL_W-1:0] canvas_right;
    logic [CANVAS_ROW_W-1:0] canvas_bottom;
    logic                    last;
  } result_t;

endpackage

### design/tdrs_cell.sv
`timescale 1ns / 1ps

module tdrs_cell #(
  parameter int INDEX        = 0,
  parameter int PANEL_COUNT  = 3,
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  tdrs_pkg::link_t  link_in,
  output tdrs_pkg::link_t  link_out,
  output logic             emit,
  output tdrs_pkg::result_t result
);
  import tdrs_pkg::*;

  localparam int X0 = INDEX * PANEL_WIDTH;
  localparam int X1 = X0 + PANEL_WIDTH - 1;
  localparam int Y1 = PANEL_HEIGHT - 1;
  localparam bit IS_TAIL = (INDEX == PANEL_COUNT - 1);

  logic    valid;
  logic    any_hit;
  region_t region;

  logic                    shape_ok;
  logic                    hit;
  logic [CANVAS_COL_W-1:0] cl;
  logic [CANVAS_COL_W-1:0] cr;
  logic [CANVAS_ROW_W-1:0] cb;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= link_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      any_hit <= link_in.any_hit;
      region  <= link_in.region;
    end
  end

  always_comb begin
    shape_ok = (region.left <= region.right) && (region.top <= region.bottom) &&
               (region.top <= REGION_W'(Y1));
    hit = shape_ok && !(region.left > REGION_W'(X1)) && !(region.right < REGION_W'(X0));
    cl = (region.left > REGION_W'(X0)) ? region.left[CANVAS_COL_W-1:0]
                                       : CANVAS_COL_W'(X0);
    cr = (region.right < REGION_W'(X1)) ? region.right[CANVAS_COL_W-1:0]
                                        : CANVAS_COL_W'(X1);
    cb = (region.bottom < REGION_W'(Y1)) ? region.bottom[CANVAS_ROW_W-1:0]
                                         : CANVAS_ROW_W'(Y1);
  end

  assign emit = valid && (hit || (IS_TAIL && !any_hit));

  always_comb begin
    result = '0;
    if (hit) begin
      result.hit           = 1'b1;
      result.panel_index   = PANEL_IDX_W'(INDEX);
      result.local_left    = LOCAL_W'(cl - CANVAS_COL_W'(X0));
      result.local_top     = region.top[LOCAL_W-1:0];
      result.local_right   = LOCAL_W'(cr - CANVAS_COL_W'(X0));
      result.local_bottom  = cb;
      result.canvas_left   = cl;
      result.canvas_top    = region.top[CANVAS_ROW_W-1:0];
      result.canvas_right  = cr;
      result.canvas_bottom = cb;
      result.last          = IS_TAIL || (region.right <= REGION_W'(X1));
    end else begin
      result.last = 1'b1;
    end
  end

  assign link_out.valid   = valid;
  assign link_out.any_hit = any_hit || hit;
  assign link_out.region  = region;

endmodule

### design/tiled_display_region_splitter.sv
`timescale 1ns / 1ps
// Splits one update region over a row of PANEL_COUNT panels.
// Input beat on s_*: tdata holds left, top, right, bottom (16 bits each).
// Output beats on m_*: one per overlapped panel in panel order, tuser = hit,
// tlast on the final beat of the region. A region that overlaps no panel
// gives a single beat with hit low, all data zero and tlast high.
// The region walks a row of PANEL_COUNT cells, one cell per cycle while the
// row is not frozen; each cell clips against its own panel and drives the
// output register when it hits, and the last cell also drives it when no cell
// hit. A beat passes through the cell registers up to its panel's cell, then
// the output register. One region is held at a time: s_tready stays low while
// any cell holds the region, so a new input beat waits until it leaves the row.
// When m_tready is low with a beat pending and a cell has the next result
// ready, the cell row freezes until the pending beat is taken; no result is
// dropped.
// rst (synchronous) empties the cell row and the output register.
module tiled_display_region_splitter #(
  parameter int PANEL_COUNT  = 3,
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 128
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // left[15:0], top[31:16], right[47:32], bottom[63:48]
  input  logic [tdrs_pkg::IN_DATA_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // panel_index[2:0], local_left[9:3], local_top[16:10], local_right[23:17],
  // local_bottom[30:24], canvas_left[40:31], canvas_top[47:41],
  // canvas_right[57:48], canvas_bottom[64:58], zero pad[71:65]
  output logic [tdrs_pkg::OUT_DATA_W-1:0] m_tdata,
  // hit[0]
  output logic                           m_tuser,
  output logic                           m_tlast
);
  import tdrs_pkg::*;

  link_t   link [0:PANEL_COUNT];
  logic    emit [0:PANEL_COUNT-1];
  result_t cell_result [0:PANEL_COUNT-1];

  logic    busy;
  logic    emit_any;
  result_t emit_result;
  logic    advance;
  result_t out_result;

  always_comb begin
    busy        = 1'b0;
    emit_any    = 1'b0;
    emit_result = '0;
    for (int i = 0; i < PANEL_COUNT; i++) begin
      busy        = busy | link[i+1].valid;
      emit_any    = emit_any | emit[i];
      emit_result = emit_result | (emit[i] ? cell_result[i] : '0);
    end
  end

  assign advance  = !(emit_any && m_tvalid && !m_tready);
  assign s_tready = !busy;

  assign link[0].valid   = s_tvalid && s_tready;
  assign link[0].any_hit = 1'b0;
  assign link[0].region  = region_t'(s_tdata);

  for (genvar g = 0; g < PANEL_COUNT; g++) begin : g_cell
    tdrs_cell #(
      .INDEX        (g),
      .PANEL_COUNT  (PANEL_COUNT),
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .link_in  (link[g]),
      .link_out (link[g+1]),
      .emit     (emit[g]),
      .result   (cell_result[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_any && advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_any && advance) begin
      out_result <= emit_result;
    end
  end

  assign m_tdata = {
    (OUT_DATA_W - 65)'(0),
    out_result.canvas_bottom,
    out_result.canvas_right,
    out_result.canvas_top,
    out_result.canvas_left,
    out_result.local_bottom,
    out_result.local_right,
    out_result.local_top,
    out_result.local_left,
    out_result.panel_index
  };
  assign m_tuser = out_result.hit;
  assign m_tlast = out_result.last;

endmodule

### design/tdrs_checker.sv
`timescale 1ns / 1ps

module tdrs_props (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [tdrs_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tuser,
  input logic                            m_tlast
);
  import tdrs_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("output beat changed while stalled");

  a_miss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && (m_tdata == '0))
    else $error("miss beat must be zero with tlast");

  a_one_region: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second region taken while one is in flight");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_DATA_W-1:65] == '0))
    else $error("pad bits of output beat not zero");

endmodule

bind tiled_display_region_splitter tdrs_props u_tdrs_props (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
